FILE: hdl/xtea_pkg.sv
`default_nettype none

package xtea_pkg;

   // cipher geometry
   localparam int unsigned ROUNDS = 32;
   localparam int unsigned STAGES = 2 * ROUNDS;
   localparam logic [31:0] DELTA = 32'h9E37_79B9;

   // register indexes of the key words
   localparam logic [1:0] KEY_WORD_0 = 2'd0;
   localparam logic [1:0] KEY_WORD_1 = 2'd1;
   localparam logic [1:0] KEY_WORD_2 = 2'd2;
   localparam logic [1:0] KEY_WORD_3 = 2'd3;

   // operation codes
   localparam logic FUNC_ENCIPHER = 1'b0;
   localparam logic FUNC_DECIPHER = 1'b1;

   // four 32-bit key words
   typedef logic [3:0][31:0] key_type;

   // one block in flight
   typedef struct packed {
      logic        func;
      logic [31:0] y;
      logic [31:0] z;
   } item_type;

   // round sum seen by half-round j when enciphering
   function automatic logic [31:0] sum_enc(input int unsigned j);
      logic [31:0] n;
      n = 32'((j >> 1) + (j & 1));
      return n * DELTA;
   endfunction

   // round sum seen by half-round j when deciphering (delta*ROUNDS for j = 0)
   function automatic logic [31:0] sum_dec(input int unsigned j);
      logic [31:0] n;
      n = 32'(ROUNDS - (j >> 1) - (j & 1));
      return n * DELTA;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/xtea_stage.sv
`default_nettype none

module xtea_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              stage_odd,
   input  wire logic [31:0]       sum_enc,
   input  wire logic [31:0]       sum_dec,
   input  wire xtea_pkg::key_type key,
   input  wire logic              valid_in,
   input  wire xtea_pkg::item_type item_in,
   output      logic              valid_out,
   output      xtea_pkg::item_type item_out
);

   logic               valid_ff;
   xtea_pkg::item_type item_ff;
   xtea_pkg::item_type item_in_next;

   logic        upd_y;
   logic [31:0] src;
   logic [31:0] tgt;
   logic [31:0] sum;
   logic [1:0]  kidx;
   logic [31:0] mixv;
   logic [31:0] tgt_new;

   // pick which half moves, its source half, sum and key word
   always_comb begin
      upd_y = ~(item_in.func ^ stage_odd);
      src   = upd_y ? item_in.z : item_in.y;
      tgt   = upd_y ? item_in.y : item_in.z;
      sum   = (item_in.func == xtea_pkg::FUNC_DECIPHER) ? sum_dec : sum_enc;
      kidx  = upd_y ? sum[1:0] : sum[12:11];
   end

   // half-round mix and update
   always_comb begin
      mixv    = (((src << 4) ^ (src >> 5)) + src) ^ (sum + key[kidx]);
      tgt_new = (item_in.func == xtea_pkg::FUNC_DECIPHER) ? (tgt - mixv) : (tgt + mixv);
      item_in_next      = item_in;
      if (upd_y) begin
         item_in_next.y = tgt_new;
      end else begin
         item_in_next.z = tgt_new;
      end
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign item_out  = item_ff;

endmodule

`default_nettype wire

FILE: hdl/xtea_outbuf.sv
`default_nettype none

module xtea_outbuf (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               valid_in,
   input  wire xtea_pkg::item_type item_in,
   output      logic               advance,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic [31:0]        rsp_out_left,
   output      logic [31:0]        rsp_out_right
);

   logic               out_valid_ff;
   logic               skid_valid_ff;
   logic [31:0]        out_left_ff;
   logic [31:0]        out_right_ff;
   xtea_pkg::item_type skid_ff;
   logic               take;
   logic               arrive;

   assign advance = ~skid_valid_ff;
   assign take    = out_valid_ff & ~rsp_stall;
   assign arrive  = advance & valid_in;

   // output register and skid control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (arrive) begin
         if (out_valid_ff && !take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   // output and skid payload
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_left_ff  <= skid_ff.y;
            out_right_ff <= skid_ff.z;
         end
      end else if (arrive) begin
         if (out_valid_ff && !take) begin
            skid_ff <= item_in;
         end else begin
            out_left_ff  <= item_in.y;
            out_right_ff <= item_in.z;
         end
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_left  = out_left_ff;
   assign rsp_out_right = out_right_ff;

endmodule

`default_nettype wire

FILE: hdl/xtea_block_cipher_top.sv
// XTEA block cipher, 64-bit block, 128-bit key, fully unrolled: each of the
// 2*ROUNDS half-rounds (64 for 32 rounds) has its own register stage, so one
// item is taken every cycle while req_stall is low, and each result passes
// through the half-round stages and then the output register. req_func selects
// encipher (0) or decipher (1) per item, so both may be mixed in the stream.
// The key words are read live by every stage and must only be written while
// no item is in flight. A stalled output holds the pipeline once one further
// result has been caught in the skid register; req_stall is then high.

`default_nettype none

module xtea_block_cipher_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_write_data,
   // input blocks
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic        req_func,
   input  wire logic [31:0] req_block_left,
   input  wire logic [31:0] req_block_right,
   // result blocks
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [31:0] rsp_out_left,
   output      logic [31:0] rsp_out_right
);

   xtea_pkg::key_type  key_ff;
   logic               advance;
   logic               valid_chain [xtea_pkg::STAGES+1];
   xtea_pkg::item_type item_chain  [xtea_pkg::STAGES+1];

   // key word registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            xtea_pkg::KEY_WORD_0: key_ff[0] <= csr_write_data;
            xtea_pkg::KEY_WORD_1: key_ff[1] <= csr_write_data;
            xtea_pkg::KEY_WORD_2: key_ff[2] <= csr_write_data;
            xtea_pkg::KEY_WORD_3: key_ff[3] <= csr_write_data;
            default: ;
         endcase
      end
   end

   // pipeline entry
   assign req_stall         = ~advance;
   assign valid_chain[0]    = req_valid;
   assign item_chain[0].func = req_func;
   assign item_chain[0].y    = req_block_left;
   assign item_chain[0].z    = req_block_right;

   // one stage per half-round
   for (genvar j = 0; j < xtea_pkg::STAGES; j++) begin : g_stage
      xtea_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_odd ((j % 2) == 1),
         .sum_enc   (xtea_pkg::sum_enc(j)),
         .sum_dec   (xtea_pkg::sum_dec(j)),
         .key       (key_ff),
         .valid_in  (valid_chain[j]),
         .item_in   (item_chain[j]),
         .valid_out (valid_chain[j+1]),
         .item_out  (item_chain[j+1])
      );
   end

   // output register with skid
   xtea_outbuf u_outbuf (
      .clock         (clock),
      .reset         (reset),
      .valid_in      (valid_chain[xtea_pkg::STAGES]),
      .item_in       (item_chain[xtea_pkg::STAGES]),
      .advance       (advance),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_left  (rsp_out_left),
      .rsp_out_right (rsp_out_right)
   );

endmodule

`default_nettype wire

FILE: tb/xtea_block_cipher_top_tb.sv
`timescale 1ns / 100ps

module xtea_block_cipher_top_tb;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 10;
   localparam int TIMEOUT_NS = CLOCK_PERIOD * 400000;

   typedef struct packed {
      logic [31:0] left;
      logic [31:0] right;
   } cipher_block_type;

   typedef struct packed {
      logic        func;
      logic [31:0] left;
      logic [31:0] right;
   } block_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = xtea_pkg::FUNC_ENCIPHER;
   logic [31:0] req_block_left = '0;
   logic [31:0] req_block_right = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_out_left;
   logic [31:0] rsp_out_right;

   // key copy, pending items and expected result blocks
   logic [31:0]      key_words [4];
   block_item_type   pending_blocks [$];
   cipher_block_type expected_blocks [$];
   int               error_count = 0;
   int               burst_left = 0;
   int               gap_left = 0;
   int               stall_mode = 0;
   int               stall_mode_left = 0;
   int               stall_cycle = 0;
   block_item_type   next_block;
   cipher_block_type observed_block;
   cipher_block_type wanted_block;

   xtea_block_cipher_top dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_block_left  (req_block_left),
      .req_block_right (req_block_right),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_left    (rsp_out_left),
      .rsp_out_right   (rsp_out_right)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // one half-round mixing term
   function automatic logic [31:0] round_mix(input logic [31:0] x, input logic [31:0] s,
                                             input logic [31:0] k);
      return (((x << 4) ^ (x >> 5)) + x) ^ (s + k);
   endfunction

   // full cipher on one block under the current key copy
   function automatic cipher_block_type xtea_transform(input logic func,
                                                       input logic [31:0] y_in,
                                                       input logic [31:0] z_in);
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] s;
      y = y_in;
      z = z_in;
      if (func == xtea_pkg::FUNC_ENCIPHER) begin
         s = '0;
         for (int r = 0; r < xtea_pkg::ROUNDS; r++) begin
            y = y + round_mix(z, s, key_words[s[1:0]]);
            s = s + xtea_pkg::DELTA;
            z = z + round_mix(y, s, key_words[s[12:11]]);
         end
      end else begin
         s = 32'(xtea_pkg::DELTA * xtea_pkg::ROUNDS);
         for (int r = 0; r < xtea_pkg::ROUNDS; r++) begin
            z = z - round_mix(y, s, key_words[s[12:11]]);
            s = s - xtea_pkg::DELTA;
            y = y - round_mix(z, s, key_words[s[1:0]]);
         end
      end
      return cipher_block_type'{left: y, right: z};
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // driver: bursts of items with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_blocks.push_back(xtea_transform(req_func, req_block_left, req_block_right));
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_blocks.size() > 0) begin
               next_block = pending_blocks.pop_front();
               req_valid <= 1'b1;
               req_func <= next_block.func;
               req_block_left <= next_block.left;
               req_block_right <= next_block.right;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: stall pattern and result check
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            observed_block = cipher_block_type'{left: rsp_out_left, right: rsp_out_right};
            if (expected_blocks.size() == 0) begin
               report_error($sformatf("result %h_%h with nothing expected",
                                      rsp_out_left, rsp_out_right));
            end else begin
               wanted_block = expected_blocks.pop_front();
               if (observed_block.left !== wanted_block.left)
                  report_error($sformatf("out_left %h, expected %h",
                                         observed_block.left, wanted_block.left));
               if (observed_block.right !== wanted_block.right)
                  report_error($sformatf("out_right %h, expected %h",
                                         observed_block.right, wanted_block.right));
            end
         end
         // switch between no stall, light, heavy and periodic stall
         if (stall_mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(64, 300);
         end else begin
            stall_mode_left--;
         end
         stall_cycle++;
         case (stall_mode)
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            3: rsp_stall <= ((stall_cycle % 7) < 3);
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   // key load, only while nothing is in flight
   task automatic load_key(input logic [31:0] k0, input logic [31:0] k1,
                           input logic [31:0] k2, input logic [31:0] k3);
      logic [1:0]  idx [4];
      logic [31:0] val [4];
      idx = '{xtea_pkg::KEY_WORD_0, xtea_pkg::KEY_WORD_1,
              xtea_pkg::KEY_WORD_2, xtea_pkg::KEY_WORD_3};
      val = '{k0, k1, k2, k3};
      for (int i = 0; i < 4; i++) begin
         @(posedge clock);
         csr_write_enable <= 1'b1;
         csr_index <= idx[i];
         csr_write_data <= val[i];
         key_words[idx[i]] = val[i];
      end
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic drain_pipeline();
      do @(posedge clock);
      while (pending_blocks.size() != 0 || req_valid || expected_blocks.size() != 0);
   endtask

   task automatic add_block(input logic func, input logic [31:0] left, input logic [31:0] right);
      pending_blocks.push_back(block_item_type'{func: func, left: left, right: right});
   endtask

   // field extremes, both operations, known vector and a round trip
   task automatic add_directed_blocks();
      cipher_block_type c;
      for (int f = 0; f < 2; f++) begin
         add_block(f[0], 32'h0000_0000, 32'h0000_0000);
         add_block(f[0], 32'hFFFF_FFFF, 32'hFFFF_FFFF);
         add_block(f[0], 32'h0000_0000, 32'hFFFF_FFFF);
         add_block(f[0], 32'hAAAA_AAAA, 32'h5555_5555);
         add_block(f[0], 32'h8000_0000, 32'h0000_0001);
      end
      add_block(xtea_pkg::FUNC_ENCIPHER, 32'h4142_4344, 32'h4546_4748);
      c = xtea_transform(xtea_pkg::FUNC_ENCIPHER, 32'h4142_4344, 32'h4546_4748);
      add_block(xtea_pkg::FUNC_DECIPHER, c.left, c.right);
   endtask

   // random blocks: round-trip pairs, all-zero or all-ones words and plain noise
   task automatic add_random_blocks(input int count);
      cipher_block_type c;
      logic [31:0]      a;
      logic [31:0]      b;
      int               kind;
      for (int n = 0; n < count; n++) begin
         a = $urandom();
         b = $urandom();
         kind = $urandom_range(0, 9);
         if (kind < 3) begin
            c = xtea_transform(xtea_pkg::FUNC_ENCIPHER, a, b);
            add_block(xtea_pkg::FUNC_ENCIPHER, a, b);
            add_block(xtea_pkg::FUNC_DECIPHER, c.left, c.right);
            n++;
         end else if (kind == 3) begin
            add_block(1'($urandom_range(0, 1)), $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0,
                      $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
         end else begin
            add_block(1'($urandom_range(0, 1)), a, b);
         end
      end
   endtask

   // stimulus phases over several keys
   initial begin
      for (int i = 0; i < 4; i++)
         key_words[i] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      add_directed_blocks();
      drain_pipeline();

      load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_directed_blocks();
      add_random_blocks(150);
      drain_pipeline();

      load_key(32'h0001_0203, 32'h0405_0607, 32'h0809_0A0B, 32'h0C0D_0E0F);
      add_random_blocks(150);
      drain_pipeline();

      load_key(32'h0, 32'h0, 32'h0, 32'h0);
      add_random_blocks(100);
      drain_pipeline();

      for (int p = 0; p < 4; p++) begin
         load_key($urandom(), $urandom(), $urandom(), $urandom());
         add_random_blocks(140);
         drain_pipeline();
      end

      // let any stray result surface
      repeat (xtea_pkg::STAGES + 10) @(posedge clock);
      if (expected_blocks.size() != 0)
         report_error($sformatf("%0d results never arrived", expected_blocks.size()));
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("timeout");
      $display("Some tests failed");
      $finish;
   end

endmodule

FILE: sim.f
hdl/xtea_pkg.sv
hdl/xtea_stage.sv
hdl/xtea_outbuf.sv
hdl/xtea_block_cipher_top.sv
tb/xtea_block_cipher_top_tb.sv
